FILE: rtl/core/tama_pkg.sv
// Shared definitions for the three-axis moving average unit.
// Holds the axis count and the divider status struct; no dependencies.
`default_nettype none

package tama_pkg;

    // Number of axes carried by one sample, and their lane positions.
    localparam int NUM_AXES = 3;
    localparam int AXIS_X   = 0;
    localparam int AXIS_Y   = 1;
    localparam int AXIS_Z   = 2;

    // Status reported by the iterative divider to the controller.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/three_axis_moving_average_unit.sv
// Three-axis moving average over a ring of WINDOW samples per axis.
// Each input transfer passes through the update, divide and output states; out_valid rises
// once the bit-serial divider, which produces one quotient bit per cycle, has finished.
// A new sample is accepted only after the previous mean has been taken at the output.
// Reset clears totals, write slot and fill count; the sample ring needs no clearing.
// Depends on tama_pkg, tama_ram and tama_div.
`default_nettype none

module three_axis_moving_average_unit
    import tama_pkg::*;
#(
    parameter int WINDOW      = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]       sample_x,
    input  wire logic signed [SAMPLE_BITS-1:0]       sample_y,
    input  wire logic signed [SAMPLE_BITS-1:0]       sample_z,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [SAMPLE_BITS-1:0]            mean_x,
    output logic signed [SAMPLE_BITS-1:0]            mean_y,
    output logic signed [SAMPLE_BITS-1:0]            mean_z,
    output logic        [$clog2(WINDOW + 1)-1:0]     samples_held
);

    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int TOTAL_W = SAMPLE_BITS + $clog2(WINDOW);
    localparam int RAM_W   = NUM_AXES * SAMPLE_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_DIVIDE,
        S_OUT
    } state_t;

    state_t                     state_reg, state_next;
    logic signed [SAMPLE_BITS-1:0] sample_in   [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] sample_reg  [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] sample_next [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] oldest      [NUM_AXES];
    logic signed [TOTAL_W-1:0]  total_reg  [NUM_AXES];
    logic signed [TOTAL_W-1:0]  total_next [NUM_AXES];
    logic signed [TOTAL_W-1:0]  total_sum  [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] mean_reg  [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] mean_next [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] quotient  [NUM_AXES];
    logic [SLOT_W-1:0]          slot_reg, slot_next;
    logic [CNT_W-1:0]           fill_reg, fill_next, fill_inc;
    logic [CNT_W-1:0]           held_reg, held_next;
    logic                       full;
    logic                       in_xfer;
    logic                       div_start;
    div_status_t                div_status;
    logic [RAM_W-1:0]           ram_wr_data;
    logic [RAM_W-1:0]           ram_rd_data;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign in_xfer   = in_valid && in_ready;

    assign sample_in[AXIS_X] = sample_x;
    assign sample_in[AXIS_Y] = sample_y;
    assign sample_in[AXIS_Z] = sample_z;

    assign mean_x       = mean_reg[AXIS_X];
    assign mean_y       = mean_reg[AXIS_Y];
    assign mean_z       = mean_reg[AXIS_Z];
    assign samples_held = held_reg;

    // Window bookkeeping: fill count saturates at WINDOW.
    assign full     = (fill_reg == CNT_W'(WINDOW));
    assign fill_inc = full ? fill_reg : (fill_reg + CNT_W'(1));

    // Pack the new sample for the ring and unpack the oldest entry read back.
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            ram_wr_data[i*SAMPLE_BITS +: SAMPLE_BITS] = sample_reg[i];
            oldest[i] = $signed(ram_rd_data[i*SAMPLE_BITS +: SAMPLE_BITS]);
            total_sum[i] = total_reg[i] + TOTAL_W'(sample_reg[i])
                           - (full ? TOTAL_W'(oldest[i]) : TOTAL_W'(0));
        end
    end

    // Sample ring: the oldest entry is read at the input transfer, overwritten in the next cycle.
    tama_ram #(
        .WIDTH (RAM_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (state_reg == S_UPDATE),
        .wr_addr (slot_reg),
        .wr_data (ram_wr_data),
        .rd_en   (in_xfer),
        .rd_addr (slot_reg),
        .rd_data (ram_rd_data)
    );

    // Divider shared by the three axes, started with the updated totals.
    assign div_start = (state_reg == S_UPDATE) && !div_status.busy;

    tama_div #(
        .DIVIDEND_W (TOTAL_W),
        .DIVISOR_W  (CNT_W),
        .QUOTIENT_W (SAMPLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (total_sum),
        .divisor  (fill_inc),
        .quotient (quotient),
        .status   (div_status)
    );

    // Controller next-state and register updates.
    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        fill_next  = fill_reg;
        held_next  = held_reg;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            sample_next[i] = sample_reg[i];
            total_next[i]  = total_reg[i];
            mean_next[i]   = mean_reg[i];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    for (int i = 0; i < NUM_AXES; i++)
                    begin
                        sample_next[i] = sample_in[i];
                    end
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    total_next[i] = total_sum[i];
                end
                fill_next  = fill_inc;
                slot_next  = (slot_reg == SLOT_W'(WINDOW - 1)) ? SLOT_W'(0)
                                                               : (slot_reg + SLOT_W'(1));
                state_next = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                if (div_status.done)
                begin
                    for (int i = 0; i < NUM_AXES; i++)
                    begin
                        mean_next[i] = quotient[i];
                    end
                    held_next  = fill_reg;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            slot_reg  <= '0;
            fill_reg  <= '0;
            held_reg  <= '0;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                sample_reg[i] <= '0;
                total_reg[i]  <= '0;
                mean_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            fill_reg  <= fill_next;
            held_reg  <= held_next;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                sample_reg[i] <= sample_next[i];
                total_reg[i]  <= total_next[i];
                mean_reg[i]   <= mean_next[i];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tama_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the sample ring of the moving average unit.
`default_nettype none

module tama_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                     wr_data,
    input  wire logic                                 rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tama_div.sv
// Iterative signed divider, one quotient bit per cycle for all three axes in lockstep.
// Depends on tama_pkg for the axis count and the status struct.
`default_nettype none

module tama_div
    import tama_pkg::*;
#(
    parameter int DIVIDEND_W = 20,
    parameter int DIVISOR_W  = 5,
    parameter int QUOTIENT_W = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic signed [DIVIDEND_W-1:0]  dividend [NUM_AXES],
    input  wire logic        [DIVISOR_W-1:0]   divisor,
    output logic signed      [QUOTIENT_W-1:0]  quotient [NUM_AXES],
    output div_status_t                        status
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] mag_reg  [NUM_AXES];
    logic [DIVIDEND_W-1:0] mag_next [NUM_AXES];
    logic [DIVIDEND_W-1:0] mag_init [NUM_AXES];
    logic [DIVISOR_W-1:0]  rem_reg  [NUM_AXES];
    logic [DIVISOR_W-1:0]  rem_next [NUM_AXES];
    logic [DIVISOR_W:0]    rem_shift [NUM_AXES];
    logic [DIVISOR_W:0]    rem_diff  [NUM_AXES];
    logic                  fits      [NUM_AXES];
    logic                  neg_reg  [NUM_AXES];
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  busy_reg;
    logic                  done_reg;

    // One restoring step per lane: shift in the next dividend bit, subtract if it fits.
    // The quotient bits shift into the low end of the magnitude register.
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            mag_init[i]  = dividend[i][DIVIDEND_W-1] ?
                           (~$unsigned(dividend[i]) + DIVIDEND_W'(1)) : $unsigned(dividend[i]);
            rem_shift[i] = {rem_reg[i], mag_reg[i][DIVIDEND_W-1]};
            rem_diff[i]  = rem_shift[i] - {1'b0, divisor_reg};
            fits[i]      = rem_shift[i] >= {1'b0, divisor_reg};
            rem_next[i]  = fits[i] ? rem_diff[i][DIVISOR_W-1:0] : rem_shift[i][DIVISOR_W-1:0];
            mag_next[i]  = {mag_reg[i][DIVIDEND_W-2:0], fits[i]};
        end
    end

    // Restore the sign: truncation toward zero follows from dividing magnitudes.
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            quotient[i] = neg_reg[i] ? $signed(QUOTIENT_W'(-mag_reg[i][QUOTIENT_W-1:0]))
                                     : $signed(mag_reg[i][QUOTIENT_W-1:0]);
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;

    // Iteration control and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            count_reg   <= '0;
            divisor_reg <= '0;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                mag_reg[i] <= '0;
                rem_reg[i] <= '0;
                neg_reg[i] <= 1'b0;
            end
        end
        else if (start)
        begin
            busy_reg    <= 1'b1;
            done_reg    <= 1'b0;
            count_reg   <= CNT_W'(DIVIDEND_W);
            divisor_reg <= divisor;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                mag_reg[i] <= mag_init[i];
                rem_reg[i] <= '0;
                neg_reg[i] <= dividend[i][DIVIDEND_W-1];
            end
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            for (int i = 0; i < NUM_AXES; i++)
            begin
                mag_reg[i] <= mag_next[i];
                rem_reg[i] <= rem_next[i];
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire
